// File: rtl/core/tapc_pkg.sv
// Shared constants and a helper function for the tinted alpha pixel compositor.
`default_nettype none

package tapc_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned NumChan = 3;
  localparam int unsigned ProdW   = 2 * ChanW;
  localparam int unsigned PixW    = 32;
  localparam int unsigned RgbW    = 24;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned AddrW   = 4;
  localparam int unsigned DataW   = 32;

  localparam logic [ModeW-1:0] MODE_FILL  = 2'd0;
  localparam logic [ModeW-1:0] MODE_COPY  = 2'd1;
  localparam logic [ModeW-1:0] MODE_BLEND = 2'd2;

  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_TINT = 2'd1;
  localparam logic [1:0] REG_FILL = 2'd2;

  localparam logic [ChanW-1:0] CHAN_MAX = 8'hff;

  // Exact floor division by 255 for any product of two 8-bit values.
  function automatic logic [ChanW-1:0] div255(input logic [ProdW-1:0] x);
    logic [ProdW:0] t;
    t = {1'b0, x} + {{ProdW{1'b0}}, 1'b1} + {{(ChanW + 1){1'b0}}, x[ProdW-1:ChanW]};
    return t[ProdW-1:ChanW];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/tinted_alpha_pixel_compositor_core.sv
// Tinted alpha pixel compositor: three-stage fill, copy and tinted blend pipeline.
// Each accepted input beat is registered in stage one, stage two and the output stage in turn.
// Multiply, blend and final divide stages pass one pixel per cycle unless output stalls.
// An output stall freezes only the full stages between the output and the first empty one.
// Reset empties the pipeline and sets mode to blend, tint to white and fill to zero.
`default_nettype none

module tinted_alpha_pixel_compositor_core import tapc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [PixW-1:0]  fg_pixel_i,
  input  wire logic [RgbW-1:0]  dest_pixel_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [PixW-1:0]       out_pixel_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic [DataW-1:0]      prdata,
  output logic                  pready
);

  logic [ModeW-1:0] mode_q;
  logic [RgbW-1:0]  tint_q;
  logic [PixW-1:0]  fill_q;
  logic             wr_en;

  logic                   v1_q, v2_q, v3_q;
  logic                   en1, en2, en3;
  logic                   blend1_q, blend2_q, blend3_q;
  logic [PixW-1:0]        pass1_q, pass2_q;
  logic [ChanW-1:0]       alpha1_q;
  logic [RgbW-1:0]        dst1_q;
  logic [ProdW-1:0]       st1_d [NumChan];
  logic [ProdW-1:0]       st1_q [NumChan];
  logic [ProdW-1:0]       sum2_d [NumChan];
  logic [ProdW-1:0]       sum2_q [NumChan];
  logic [PixW-1:0]        out_d;
  logic [PixW-1:0]        out_q;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_BLEND;
      tint_q <= {RgbW{1'b1}};
      fill_q <= '0;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_MODE: mode_q <= pwdata[ModeW-1:0];
        REG_TINT: tint_q <= pwdata[RgbW-1:0];
        REG_FILL: fill_q <= pwdata[PixW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MODE: prdata = {{(DataW - ModeW){1'b0}}, mode_q};
      REG_TINT: prdata = {{(DataW - RgbW){1'b0}}, tint_q};
      REG_FILL: prdata = fill_q;
      default:  prdata = '0;
    endcase
  end

  assign en3        = !out_stall_i || !v3_q;
  assign en2        = en3 || !v2_q;
  assign en1        = en2 || !v1_q;
  assign in_stall_o = !en1;

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      st1_d[c] = ProdW'(fg_pixel_i[c*ChanW +: ChanW]) * ProdW'(tint_q[c*ChanW +: ChanW]);
    end
  end

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      sum2_d[c] = ProdW'(ProdW'(div255(st1_q[c])) * ProdW'(alpha1_q))
                + ProdW'(ProdW'(dst1_q[c*ChanW +: ChanW]) * ProdW'(CHAN_MAX - alpha1_q));
    end
  end

  always_comb begin
    out_d = pass2_q;
    if (blend2_q) begin
      out_d = {{(PixW - RgbW){1'b0}}, div255(sum2_q[2]), div255(sum2_q[1]),
               div255(sum2_q[0])};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      blend1_q <= (mode_q != MODE_FILL) && (mode_q != MODE_COPY);
      pass1_q  <= (mode_q == MODE_FILL) ? fill_q : fg_pixel_i;
      alpha1_q <= fg_pixel_i[PixW-1 -: ChanW];
      dst1_q   <= dest_pixel_i;
      st1_q    <= st1_d;
    end
    if (en2) begin
      blend2_q <= blend1_q;
      pass2_q  <= pass1_q;
      sum2_q   <= sum2_d;
    end
    if (en3) begin
      blend3_q <= blend2_q;
      out_q    <= out_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_pixel_o = out_q;

  a_empty_out_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("Input stalled while the output stage is empty.");

  a_full_stall_backs_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && v3_q && out_stall_i) |-> in_stall_o)
    else $error("Full pipeline failed to stall its input.");

  a_accept_fills_stage1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v1_q)
    else $error("Accepted beat did not reach the first stage.");

  a_blend_top_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && blend3_q) |-> (out_pixel_o[PixW-1 -: ChanW] == '0))
    else $error("Blended beat has a non-zero top byte.");

endmodule

`default_nettype wire

// File: bench/tb_tinted_alpha_pixel_compositor_core.sv
// Self-checking testbench for the tinted alpha pixel compositor core.
`timescale 1ns / 100ps

module tb_tinted_alpha_pixel_compositor_core;
  import tapc_pkg::*;

  localparam logic [ModeW-1:0] MODE_SPARE = 2'd3;
  localparam logic [1:0]       REG_UNUSED = 2'd3;
  localparam int unsigned      HoldCycles = 150;
  localparam int unsigned      DrainLimit = 2000;

  logic             clk = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [PixW-1:0]  fg_pixel = '0;
  logic [RgbW-1:0]  dest_pixel = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [PixW-1:0]  out_pixel;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  logic [ModeW-1:0] cfg_mode = MODE_BLEND;
  logic [RgbW-1:0]  cfg_tint = 24'hffffff;
  logic [PixW-1:0]  cfg_fill = '0;

  logic [PixW-1:0] expected_pixels[$];
  int unsigned     pixels_checked = 0;
  int unsigned     reg_writes = 0;
  int unsigned     stalled_input_cycles = 0;
  int unsigned     fail_count = 0;
  int unsigned     burst_left = 0;
  bit              hold_req = 1'b0;

  tinted_alpha_pixel_compositor_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .fg_pixel_i  (fg_pixel),
    .dest_pixel_i(dest_pixel),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_pixel_o (out_pixel),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic logic [PixW-1:0] composite_pixel(input logic [PixW-1:0] src,
                                                       input logic [RgbW-1:0] dst);
    logic [PixW-1:0] res;
    int unsigned lim, a, s, t, d, st, c;
    lim = CHAN_MAX;
    res = '0;
    case (cfg_mode)
      MODE_FILL: res = cfg_fill;
      MODE_COPY: res = src;
      default: begin
        a = src[31:24];
        for (int k = 0; k < NumChan; k++) begin
          s = src[ChanW*k +: ChanW];
          t = cfg_tint[ChanW*k +: ChanW];
          d = dst[ChanW*k +: ChanW];
          st = (s * t) / lim;
          c = (d * (lim - a) + st * a) / lim;
          res[ChanW*k +: ChanW] = c[ChanW-1:0];
        end
      end
    endcase
    return res;
  endfunction

  function automatic logic [PixW-1:0] random_source();
    logic [ChanW-1:0] alpha;
    case ($urandom_range(0, 7))
      0: alpha = '0;
      1: alpha = CHAN_MAX;
      default: alpha = ChanW'($urandom_range(0, 255));
    endcase
    return {alpha, 24'($urandom())};
  endfunction

  // The receiver either holds off for a counted stretch or stalls at a rate that changes.
  always begin : stall_pattern
    int unsigned pattern_left;
    int unsigned stall_pct;
    @(posedge clk);
    if (hold_req) begin
      out_stall <= 1'b1;
      repeat (HoldCycles) @(posedge clk);
      hold_req = 1'b0;
    end else begin
      if (pattern_left == 0) begin
        pattern_left = 64;
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      pattern_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_output
    logic [PixW-1:0] want;
    if (rst_ni && in_valid && in_stall) stalled_input_cycles++;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("out_pixel: unexpected beat, expected none, actual %h", out_pixel);
        fail_count++;
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (out_pixel !== want) begin
          $error("out_pixel mismatch: expected %h, actual %h", want, out_pixel);
          fail_count++;
        end
      end
    end
  end

  task automatic send_pixel(input logic [PixW-1:0] src, input logic [RgbW-1:0] dst);
    int unsigned gap;
    in_valid <= 1'b1;
    fg_pixel <= src;
    dest_pixel <= dst;
    do @(posedge clk); while (in_stall);
    expected_pixels.push_back(composite_pixel(src, dst));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_pipeline();
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      $error("out_pixel: %0d beats never arrived", expected_pixels.size());
      fail_count += expected_pixels.size();
      expected_pixels.delete();
    end
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [DataW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_MODE: cfg_mode = value[ModeW-1:0];
      REG_TINT: cfg_tint = value[RgbW-1:0];
      REG_FILL: cfg_fill = value;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic test_reset_defaults();
    send_pixel(32'h00123456, 24'habcdef);
    send_pixel(32'hffffffff, 24'h000000);
    send_pixel(32'h80ff00ff, 24'h00ff00);
    send_pixel(32'hffffffff, 24'hffffff);
    drain_pipeline();
  endtask

  task automatic test_fill_mode();
    write_register(REG_MODE, {30'h0, MODE_FILL});
    write_register(REG_FILL, 32'hffffffff);
    send_pixel(32'h00000000, 24'h000000);
    send_pixel(32'hffffffff, 24'hffffff);
    drain_pipeline();
    write_register(REG_FILL, 32'h00000000);
    send_pixel(32'h12345678, 24'h9abcde);
    drain_pipeline();
  endtask

  task automatic test_copy_mode();
    write_register(REG_MODE, {30'h3fffffff, MODE_COPY} & 32'hfffffffd);
    send_pixel(32'h00000000, 24'hffffff);
    send_pixel(32'hffffffff, 24'h000000);
    send_pixel(32'h80000001, 24'h5a5a5a);
    drain_pipeline();
  endtask

  task automatic test_tinted_blend();
    write_register(REG_MODE, {30'h0, MODE_BLEND});
    write_register(REG_TINT, 32'h00000000);
    send_pixel(32'hffffffff, 24'h000000);
    send_pixel(32'h80ffffff, 24'hffffff);
    drain_pipeline();
    write_register(REG_TINT, 32'hff80ff40);
    send_pixel(32'h00ffffff, 24'h123456);
    send_pixel(32'hffffffff, 24'hffffff);
    send_pixel(32'h7fc03f80, 24'h000000);
    send_pixel(32'h01ffffff, 24'hffffff);
    drain_pipeline();
  endtask

  task automatic test_spare_mode();
    write_register(REG_MODE, {30'h0, MODE_SPARE});
    send_pixel(32'hc0a0b0c0, 24'h102030);
    send_pixel(32'h40ffffff, 24'hffffff);
    drain_pipeline();
  endtask

  task automatic test_unmapped_register();
    write_register(REG_UNUSED, 32'hffffffff);
    send_pixel(32'h9955aa33, 24'h66cc11);
    send_pixel(32'hfe010203, 24'hfdfcfb);
    drain_pipeline();
  endtask

  task automatic test_output_hold_off();
    write_register(REG_MODE, {30'h0, MODE_BLEND});
    write_register(REG_TINT, 32'($urandom()));
    hold_req = 1'b1;
    repeat (40) send_pixel(random_source(), 24'($urandom()));
    while (hold_req) @(posedge clk);
    drain_pipeline();
  endtask

  task automatic test_random_traffic();
    logic [ModeW-1:0] mode;
    logic [DataW-1:0] tint;
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 9))
        0: mode = MODE_FILL;
        1: mode = MODE_COPY;
        2: mode = MODE_SPARE;
        default: mode = MODE_BLEND;
      endcase
      case ($urandom_range(0, 7))
        0: tint = 32'h00000000;
        1: tint = 32'h00ffffff;
        default: tint = $urandom();
      endcase
      write_register(REG_MODE, {30'($urandom()), mode});
      write_register(REG_TINT, tint);
      write_register(REG_FILL, $urandom());
      repeat ($urandom_range(75, 95)) send_pixel(random_source(), 24'($urandom()));
      drain_pipeline();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_fill_mode();
    test_copy_mode();
    test_tinted_blend();
    test_spare_mode();
    test_unmapped_register();
    test_output_hold_off();
    test_random_traffic();
    drain_pipeline();
    $display("Checked %0d pixel beats over %0d register writes in fill, copy, blend %s",
             pixels_checked, reg_writes, "and spare modes.");
    $display("The input was held back for %0d cycles by output stalls.", stalled_input_cycles);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2400000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
